>>> hw/rtl/lifn_pkg.sv
package lifn_pkg;

   // input word
   typedef struct packed {
      logic [2:0]         opcode;
      logic [5:0]         synapse_index;
      logic signed [15:0] signed_value;
   } req_type;

   // result word
   typedef struct packed {
      logic               fired;
      logic               spike_out;
      logic signed [15:0] potential;
      logic [14:0]        weight_read;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_SPIKE = 3'd0,
      OP_PULSE = 3'd1,
      OP_TICK  = 3'd2,
      OP_TRAIN = 3'd3,
      OP_LOAD  = 3'd4,
      OP_RESET = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPER,
      S_DRIVE,
      S_LEAK,
      S_SETTLE,
      S_DONE
   } state_type;

   localparam logic [1:0] CSR_RESISTANCE = 2'd0;
   localparam logic [1:0] CSR_INV_TAU    = 2'd1;
   localparam logic [1:0] CSR_REST       = 2'd2;
   localparam logic [1:0] CSR_LRATE      = 2'd3;

   localparam logic [15:0] RESISTANCE_RST = 16'd256;
   localparam logic [15:0] INV_TAU_RST    = 16'd6554;
   localparam logic [15:0] REST_RST       = 16'd0;
   localparam logic [15:0] LRATE_RST      = 16'd164;

   localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
   localparam logic [14:0]        WEIGHT_MAX = 15'd16384;

   localparam logic signed [40:0] SUM_MAX = 41'sd8388607;
   localparam logic signed [40:0] SUM_MIN = -41'sd8388608;
   localparam logic signed [40:0] POT_MAX = 41'sd32767;
   localparam logic signed [40:0] POT_MIN = -41'sd32768;
   localparam logic signed [40:0] WGT_MAX = 41'sd16384;

   function automatic logic signed [23:0] sat24(input logic signed [40:0] v);
      logic signed [40:0] r;
      if (v > SUM_MAX) begin
         r = SUM_MAX;
      end else if (v < SUM_MIN) begin
         r = SUM_MIN;
      end else begin
         r = v;
      end
      return r[23:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
      logic signed [40:0] r;
      if (v > POT_MAX) begin
         r = POT_MAX;
      end else if (v < POT_MIN) begin
         r = POT_MIN;
      end else begin
         r = v;
      end
      return r[15:0];
   endfunction

   // weights live in [0, 1.0]
   function automatic logic [14:0] clamp_weight(input logic signed [40:0] v);
      logic signed [40:0] r;
      if (v < 41'sd0) begin
         r = 41'sd0;
      end else if (v > WGT_MAX) begin
         r = WGT_MAX;
      end else begin
         r = v;
      end
      return r[14:0];
   endfunction

endpackage

>>> hw/rtl/lifn_mul.sv
module lifn_mul
   import lifn_pkg::*;
(
   input  logic               clock,
   input  logic signed [23:0] mul_a,
   input  logic signed [16:0] mul_b,
   output logic signed [40:0] mul_prod_ff
);

   logic signed [40:0] mul_prod_in;

   assign mul_prod_in = 41'(mul_a) * 41'(mul_b);

   always_ff @(posedge clock) begin
      mul_prod_ff <= mul_prod_in;
   end

endmodule

>>> hw/rtl/lifn_wmem.sv
module lifn_wmem
   import lifn_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [14:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [14:0]   rd_data_ff
);

   logic [14:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

>>> hw/rtl/lif_neuron_with_weight_learning_top.sv
// channel | direction | handshake              | word
// req     | in        | req_valid / req_stall  | req_type: opcode, synapse_index, signed_value
// rsp     | out       | rsp_valid / rsp_stall  | rsp_type: fired, spike_out, potential, weight_read
// csr     | in        | csr_valid / csr_ready  | csr_index (2b), csr_data (16b)
//
// One word at a time. Spike, pulse, load, reset and unused opcodes go through the
// operate and done states; train on a valid synapse adds settle; tick runs operate,
// drive, leak, settle, done. The tick passes twice through the single shared
// multiplier (drive, then leak), with a saturate stage between.
// Reset is synchronous; it clears potential, input sum and flag and reloads the csr
// defaults. Weights are not cleared. A held result does not block the next accept;
// the sequencer waits in its last state only while a previous result is stalled.
module lif_neuron_with_weight_learning_top
   import lifn_pkg::*;
#(
   parameter int SYNAPSES = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;

   state_type          state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               idx_ok_ff, idx_ok_in;
   logic signed [15:0] val_ff, val_in;

   logic signed [23:0] sum_ff, sum_in;
   logic signed [15:0] pot_ff, pot_in;
   logic               flag_ff, flag_in;
   logic               fired_ff, fired_in;
   logic [14:0]        wt_ff, wt_in;
   logic signed [23:0] diff_ff, diff_in;

   logic [15:0]        res_ff, itc_ff, rest_ff, lr_ff;

   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [23:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [40:0] mul_prod_ff;

   logic               mem_we;
   logic [14:0]        mem_wdata;
   logic [AW-1:0]      req_addr;
   logic [14:0]        mem_rdata_ff;

   assign req_addr  = AW'({{AW{1'b0}}, req_data.synapse_index});
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   lifn_mul u_mul (
      .clock       (clock),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .mul_prod_ff (mul_prod_ff)
   );

   lifn_wmem #(
      .DEPTH (SYNAPSES),
      .AW    (AW)
   ) u_wmem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (addr_ff),
      .wr_data    (mem_wdata),
      .rd_addr    (req_addr),
      .rd_data_ff (mem_rdata_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff  <= RESISTANCE_RST;
         itc_ff  <= INV_TAU_RST;
         rest_ff <= REST_RST;
         lr_ff   <= LRATE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RESISTANCE: res_ff  <= csr_data;
            CSR_INV_TAU:    itc_ff  <= csr_data;
            CSR_REST:       rest_ff <= csr_data;
            CSR_LRATE:      lr_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         pot_ff       <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         pot_ff       <= pot_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      addr_ff   <= addr_in;
      idx_ok_ff <= idx_ok_in;
      val_ff    <= val_in;
      fired_ff  <= fired_in;
      wt_ff     <= wt_in;
      diff_ff   <= diff_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      logic signed [23:0] drive;
      logic signed [15:0] np;
      logic [14:0]        w;

      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      idx_ok_in    = idx_ok_ff;
      val_in       = val_ff;
      sum_in       = sum_ff;
      pot_in       = pot_ff;
      flag_in      = flag_ff;
      fired_in     = fired_ff;
      wt_in        = wt_ff;
      diff_in      = diff_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = sum_ff;
      mul_b        = {1'b0, res_ff};
      mem_we       = 1'b0;
      mem_wdata    = '0;
      drive        = '0;
      np           = '0;
      w            = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               addr_in   = req_addr;
               idx_ok_in = (int'(req_data.synapse_index) < SYNAPSES);
               val_in    = req_data.signed_value;
               state_in  = S_OPER;
            end
         end
         S_OPER: begin
            // weight read was launched at accept
            wt_in    = mem_rdata_ff;
            fired_in = 1'b0;
            state_in = S_DONE;
            unique case (op_ff)
               OP_SPIKE: begin
                  if (idx_ok_ff) begin
                     sum_in = sat24(41'(sum_ff) + 41'($signed({1'b0, mem_rdata_ff})));
                  end
               end
               OP_PULSE: begin
                  sum_in = sat24(41'(sum_ff) + 41'(val_ff));
               end
               OP_TICK: begin
                  mul_a    = sum_ff;
                  mul_b    = {1'b0, res_ff};
                  state_in = S_DRIVE;
               end
               OP_TRAIN: begin
                  mul_a = 24'(val_ff);
                  mul_b = 17'($signed(lr_ff));
                  if (idx_ok_ff) begin
                     state_in = S_SETTLE;
                  end
               end
               OP_LOAD: begin
                  if (idx_ok_ff) begin
                     mem_we    = 1'b1;
                     mem_wdata = clamp_weight(41'(val_ff));
                     wt_in     = mem_wdata;
                  end
               end
               OP_RESET: begin
                  sum_in  = '0;
                  pot_in  = '0;
                  flag_in = 1'b0;
               end
               default: ;
            endcase
         end
         S_DRIVE: begin
            drive    = sat24(mul_prod_ff >>> 8);
            diff_in  = sat24(41'(drive) - 41'(pot_ff));
            state_in = S_LEAK;
         end
         S_LEAK: begin
            mul_a    = diff_ff;
            mul_b    = {1'b0, itc_ff};
            state_in = S_SETTLE;
         end
         S_SETTLE: begin
            if (op_ff == OP_TICK) begin
               np     = sat16(41'(pot_ff) + (mul_prod_ff >>> 16));
               sum_in = '0;
               if (np >= ONE_Q14) begin
                  pot_in   = $signed(rest_ff);
                  flag_in  = 1'b1;
                  fired_in = 1'b1;
               end else if (np < 16'sd0) begin
                  pot_in  = '0;
                  flag_in = 1'b0;
               end else begin
                  pot_in  = np;
                  flag_in = 1'b0;
               end
            end else begin
               // training: weight += factor * rate, Q2.14
               w         = clamp_weight(41'($signed({1'b0, wt_ff})) + (mul_prod_ff >>> 14));
               mem_we    = 1'b1;
               mem_wdata = w;
               wt_in     = w;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.fired       = fired_ff;
               rsp_in.spike_out   = flag_ff;
               rsp_in.potential   = pot_ff;
               rsp_in.weight_read = idx_ok_ff ? wt_ff : 15'd0;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_fired_sets_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.fired || rsp_ff.spike_out))
      else $error("fired result without output flag");

   a_wmem_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_OPER) || (state_ff == S_SETTLE)))
      else $error("weight write outside execute states");

   a_tick_clears_sum: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SETTLE) && (op_ff == OP_TICK)) |=> (sum_ff == '0))
      else $error("input sum not cleared by tick");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("result dropped while output stalled");
`endif

endmodule
